// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CISP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cisp check failed: same-cycle rule");

// Next-cycle implication, ignored while reset is high.
`define CISP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cisp check failed: next-cycle rule");

`endif

// ===== rtl/cisp_pkg.sv =====
// Shared constants, types and codes for the integer list parser.
`timescale 1ns / 1ps
package cisp_pkg;

  // sizing
  localparam int MaxValues   = 64;
  localparam int MaxCapacity = 4096;
  localparam int PosW        = $clog2(MaxCapacity);
  localparam int CntW        = $clog2(MaxValues + 1);
  localparam int IdxW        = $clog2(MaxValues);
  localparam int ValW        = 32;
  localparam int ByteW       = 8;
  localparam int CapW        = 13;
  localparam int LimW        = 7;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 13;

  // output word layout
  localparam int OutFieldW   = ValW + IdxW + CntW;
  localparam int OutDataW    = ((OutFieldW + 7) / 8) * 8;
  localparam int OutPadW     = OutDataW - OutFieldW;
  localparam int UserW       = 2;
  localparam int UserDoneBit = 0;
  localparam int UserOvrBit  = 1;
  localparam int IdxLsb      = ValW;
  localparam int CntLsb      = ValW + IdxW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLimit    = 1'b1;

  // configuration reset values
  localparam logic [CapW-1:0] CapReset = CapW'(64);
  localparam logic [LimW-1:0] LimReset = LimW'(8);

  // characters
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // classified input word
  typedef struct packed {
    logic       nul;
    logic       sep;
    logic       comma;
    logic       minus;
    logic       digit;
    logic [3:0] dval;
  } class_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [PosW-1:0] cap_last;
    logic [CntW-1:0] lim;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic signed [ValW-1:0] parsed_value;
    logic [IdxW-1:0]        value_index;
    logic                   is_done;
    logic [CntW-1:0]        value_count;
    logic                   overrun;
    logic                   last_of_run;
  } res_t;

  // results produced for one byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== rtl/cisp_front.sv =====
// Front end: accepts bytes, classifies them and queues them for the parser.
`timescale 1ns / 1ps
module cisp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cisp_pkg::ByteW-1:0]    s_tdata,
  output logic                          q_valid,
  output cisp_pkg::class_t              q_word,
  input  logic                          q_pop
);

  cisp_pkg::class_t cls;
  cisp_pkg::class_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       acc;

  // byte classification
  always_comb begin
    cls.nul   = (s_tdata == cisp_pkg::ChNul);
    cls.comma = (s_tdata == cisp_pkg::ChComma);
    cls.sep   = (s_tdata == cisp_pkg::ChSpace) || (s_tdata == cisp_pkg::ChComma);
    cls.minus = (s_tdata == cisp_pkg::ChMinus);
    cls.digit = (s_tdata >= cisp_pkg::ChZero) && (s_tdata <= cisp_pkg::ChNine);
    cls.dval  = s_tdata[3:0];
  end

  assign s_tready = (count != 2'd2);
  assign acc      = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_word   = slot[rp];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (acc) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, acc} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slot[wp] <= cls;
    end
  end

endmodule

// ===== rtl/cisp_parser.sv =====
// Back end: token scanner, accumulator and result generation.
`timescale 1ns / 1ps
module cisp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  cisp_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  cisp_pkg::class_t      q_word,
  output logic                  q_pop,
  input  logic                  room,
  output cisp_pkg::push_t       push
);

  localparam logic [2:0] ModeSep       = 3'd0;
  localparam logic [2:0] ModeMinus     = 3'd1;
  localparam logic [2:0] ModeDigits    = 3'd2;
  localparam logic [2:0] ModeSkipComma = 3'd3;
  localparam logic [2:0] ModeSkipJunk  = 3'd4;

  logic [2:0]                    mode;
  logic                          minus;
  logic [cisp_pkg::ValW-1:0]     acc;
  logic [cisp_pkg::CntW-1:0]     emitted;
  logic [cisp_pkg::PosW-1:0]     pos;

  logic [2:0]                    mode_next;
  logic                          minus_next;
  logic [cisp_pkg::ValW-1:0]     acc_next;
  logic [cisp_pkg::CntW-1:0]     emitted_next;
  logic [cisp_pkg::PosW-1:0]     pos_next;

  logic                          ovr;
  logic                          taking;
  logic                          emit_val;
  logic [2:0]                    mode_mid;
  logic [cisp_pkg::CntW-1:0]     emitted_mid;
  logic [cisp_pkg::ValW-1:0]     value;
  cisp_pkg::res_t                r_val;
  cisp_pkg::res_t                r_done;

  assign q_pop = q_valid && room;

  always_comb begin
    ovr         = !q_word.nul && (pos >= cfg.cap_last);
    taking      = (emitted < cfg.lim);
    emit_val    = (mode == ModeDigits) && !q_word.digit && taking && !ovr;
    value       = minus ? (cisp_pkg::ValW'(0) - acc) : acc;
    emitted_mid = emitted + {{(cisp_pkg::CntW-1){1'b0}}, emit_val};

    // a value ends at the first non-digit
    mode_mid = mode;
    if (mode == ModeDigits && !q_word.digit) begin
      mode_mid = q_word.sep ? ModeSep : ModeSkipJunk;
    end

    // value result
    r_val              = '0;
    r_val.parsed_value = value;
    r_val.value_index  = emitted[cisp_pkg::IdxW-1:0];

    // done or overrun result
    r_done             = '0;
    r_done.is_done     = 1'b1;
    r_done.last_of_run = 1'b1;
    if (ovr) begin
      r_done.overrun = 1'b1;
    end else begin
      r_done.value_count = emitted_mid;
    end

    // pack results for the output queue
    push = '0;
    if (q_pop) begin
      if (ovr) begin
        push.n  = 2'd1;
        push.r0 = r_done;
      end else if (emit_val && q_word.nul) begin
        push.n  = 2'd2;
        push.r0 = r_val;
        push.r1 = r_done;
      end else if (emit_val) begin
        push.n  = 2'd1;
        push.r0 = r_val;
        push.r0.last_of_run = 1'b1;
      end else if (q_word.nul) begin
        push.n  = 2'd1;
        push.r0 = r_done;
      end
    end

    // scanner state
    mode_next    = mode_mid;
    minus_next   = minus;
    acc_next     = acc;
    emitted_next = emitted_mid;
    pos_next     = pos + cisp_pkg::PosW'(1);
    if (ovr || q_word.nul) begin
      mode_next    = ModeSep;
      minus_next   = 1'b0;
      acc_next     = '0;
      emitted_next = '0;
      pos_next     = '0;
    end else begin
      case (mode_mid)
        ModeDigits: begin
          acc_next = (acc << 3) + (acc << 1) + {28'd0, q_word.dval};
        end
        ModeMinus: begin
          if (q_word.digit) begin
            acc_next  = {28'd0, q_word.dval};
            mode_next = ModeDigits;
          end else begin
            mode_next = q_word.comma ? ModeSep : ModeSkipComma;
          end
        end
        ModeSkipComma: begin
          if (q_word.comma) begin
            mode_next = ModeSep;
          end
        end
        ModeSkipJunk: begin
          if (q_word.sep) begin
            mode_next = ModeSep;
          end
        end
        default: begin
          if (q_word.sep) begin
            mode_next = ModeSep;
          end else if (q_word.minus) begin
            minus_next = 1'b1;
            mode_next  = ModeMinus;
          end else if (q_word.digit) begin
            minus_next = 1'b0;
            acc_next   = {28'd0, q_word.dval};
            mode_next  = ModeDigits;
          end else begin
            mode_next = ModeSkipComma;
          end
        end
      endcase
      if (mode_next == ModeSep) begin
        minus_next = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= ModeSep;
      minus   <= 1'b0;
      acc     <= '0;
      emitted <= '0;
      pos     <= '0;
    end else if (q_pop) begin
      mode    <= mode_next;
      minus   <= minus_next;
      acc     <= acc_next;
      emitted <= emitted_next;
      pos     <= pos_next;
    end
  end

endmodule

// ===== rtl/cisp_out_q.sv =====
// Result queue: takes up to two per cycle, shows one per cycle on pop.
`timescale 1ns / 1ps
module cisp_out_q (
  input  logic               clk,
  input  logic               rst,
  input  cisp_pkg::push_t    push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_pop,
  output cisp_pkg::res_t     out_res
);

  cisp_pkg::res_t mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       pop;

  // room for a worst-case pair of results
  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_pop;
  assign out_res   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.n;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push.n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wp + 2'd1] <= push.r1;
    end
  end

endmodule

// ===== rtl/csv_integer_series_parser.sv =====
// Top level of the comma/space separated signed integer list parser.
// One text byte is taken per cycle while s_tready is high, and one result word
// leaves per cycle while m_tready is high. A byte is registered in a two-entry
// input queue and parsed once at its head with room in the result queue; its
// results are registered in a four-entry result queue that feeds the output. A
// value ended by the terminator gives two results, which leave the output one
// at a time; the output port's one word per cycle sets the sustained rate when
// results come in pairs. Values are reported as they complete; a string with
// no terminator within buffer_capacity bytes ends with an overrun word (tuser
// overrun set, count zero), after which values already sent for it are to be
// discarded. Configuration is taken at any time, one write per cycle, and must
// only change while the block is idle. No clearing pass after reset.
`timescale 1ns / 1ps
module csv_integer_series_parser (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cisp_pkg::ByteW-1:0]       s_tdata,   // text_byte
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cisp_pkg::OutDataW-1:0]    m_tdata,   // parsed_value, value_index,
                                                      // value_count, zero pad
  output logic [cisp_pkg::UserW-1:0]       m_tuser,   // is_done, overrun
  output logic                             m_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cisp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cisp_pkg::CfgDataW-1:0]    cfg_data
);

  cisp_pkg::cfg_t   cfg;
  cisp_pkg::class_t q_word;
  cisp_pkg::push_t  push;
  cisp_pkg::res_t   res;
  logic             q_valid;
  logic             q_pop;
  logic             room;

  logic [cisp_pkg::CapW-1:0] cap_raw;
  logic [cisp_pkg::CapW-1:0] cap_eff;
  logic [cisp_pkg::LimW-1:0] lim_raw;
  logic [cisp_pkg::LimW-1:0] lim_eff;

  // clamp configuration on the way in
  always_comb begin
    cap_raw = cfg_data[cisp_pkg::CapW-1:0];
    lim_raw = cfg_data[cisp_pkg::LimW-1:0];
    if (cap_raw == '0) begin
      cap_eff = cisp_pkg::CapW'(1);
    end else if (cap_raw > cisp_pkg::CapW'(cisp_pkg::MaxCapacity)) begin
      cap_eff = cisp_pkg::CapW'(cisp_pkg::MaxCapacity);
    end else begin
      cap_eff = cap_raw;
    end
    if (lim_raw > cisp_pkg::LimW'(cisp_pkg::MaxValues)) begin
      lim_eff = cisp_pkg::LimW'(cisp_pkg::MaxValues);
    end else begin
      lim_eff = lim_raw;
    end
  end

  assign cfg_ready = 1'b1;

  // configuration registers (stored as last allowed position and clamped limit)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cap_last <= cisp_pkg::PosW'(cisp_pkg::CapReset - cisp_pkg::CapW'(1));
      cfg.lim      <= cisp_pkg::CntW'(cisp_pkg::LimReset);
    end else if (cfg_valid) begin
      case (cfg_index)
        cisp_pkg::CfgCapacity: begin
          cfg.cap_last <= cisp_pkg::PosW'(cap_eff - cisp_pkg::CapW'(1));
        end
        cisp_pkg::CfgLimit: begin
          cfg.lim <= cisp_pkg::CntW'(lim_eff);
        end
        default: begin
        end
      endcase
    end
  end

  cisp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  cisp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .room    (room),
    .push    (push)
  );

  cisp_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_pop   (m_tready),
    .out_res   (res)
  );

  // output word packing
  assign m_tdata = {{cisp_pkg::OutPadW{1'b0}}, res.value_count, res.value_index,
                    res.parsed_value};
  assign m_tuser = {res.overrun, res.is_done};
  assign m_tlast = res.last_of_run;

endmodule

// ===== rtl/cisp_checker.sv =====
// Port-level checks for the integer list parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cisp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cisp_pkg::OutDataW-1:0]    m_tdata,
  input logic [cisp_pkg::UserW-1:0]       m_tuser,
  input logic                             m_tlast
);

  logic is_done;
  logic is_ovr;
  logic [cisp_pkg::CntW-1:0] count;

  assign is_done = m_tuser[cisp_pkg::UserDoneBit];
  assign is_ovr  = m_tuser[cisp_pkg::UserOvrBit];
  assign count   = m_tdata[cisp_pkg::CntLsb +: cisp_pkg::CntW];

  // a stalled result stays offered
  `CISP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  // overrun word is a done word that closes the run with count zero
  `CISP_ASSERT_SAME(a_ovr_shape, m_tvalid && is_ovr, is_done && m_tlast && (count == '0))
  // every done word is the last of its byte
  `CISP_ASSERT_SAME(a_done_last, m_tvalid && is_done, m_tlast)
  // value words carry no count
  `CISP_ASSERT_SAME(a_val_count, m_tvalid && !is_done, (count == '0) && !is_ovr)

endmodule

bind csv_integer_series_parser cisp_checker u_cisp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the comma/space separated integer list parser.
`timescale 1ns / 1ps
module testbench;
  import cisp_pkg::*;

  localparam int CycleLimit  = 1_500_000;
  localparam int DrainCycles = 6;
  localparam int ShowLimit   = 40;

  // parser scan states of the predictor
  typedef enum logic [2:0] {
    SCAN_SEP, SCAN_MINUS, SCAN_DIGITS, SCAN_SKIP_COMMA, SCAN_SKIP_JUNK
  } scan_e;

  // directed stimulus table
  typedef enum logic {ROW_BYTE, ROW_SET_CAP} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic [12:0] data;
    bit          typed;
    res_t        want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [ByteW-1:0]     s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic [UserW-1:0]     m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  csv_integer_series_parser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state and its copy of the registers
  scan_e       sc_mode;
  logic        neg_pending;
  logic [31:0] acc_value;
  logic [6:0]  taken_count;
  int          char_pos;
  logic [12:0] cap_reg;
  logic [6:0]  lim_reg;

  res_t       expected_words[$];
  logic [7:0] text_buf[$];
  row_t       dir_rows[$];

  int  errors = 0;
  int  cycles = 0;
  int  bytes_sent = 0;
  int  words_checked = 0;
  int  done_words = 0;
  int  overrun_words = 0;
  int  settings_run = 0;
  int  rx_hold = 0;
  bit  calm = 1'b0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;

  string wide_numbers [4] = '{"2147483647", "2147483648", "4294967295", "4294967296"};

  // one line per mismatch, printing stops after a while
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (errors < ShowLimit)
      $display("mismatch at word %0d: %s got %0d want %0d", words_checked, what, got, want);
    errors++;
  endtask

  function automatic res_t mk_word(input logic [31:0] val, input logic [5:0] idx,
                                   input logic done, input logic [6:0] cnt,
                                   input logic ovr, input logic last);
    res_t w;
    w.parsed_value = val;
    w.value_index  = idx;
    w.is_done      = done;
    w.value_count  = cnt;
    w.overrun      = ovr;
    w.last_of_run  = last;
    return w;
  endfunction

  function automatic void restart_scan();
    sc_mode     = SCAN_SEP;
    neg_pending = 1'b0;
    acc_value   = '0;
    taken_count = '0;
    char_pos    = 0;
  endfunction

  // predicts the result words one text byte causes
  function automatic void parse_char(input logic [7:0] c, output int n,
                                     output res_t r0, output res_t r1);
    int   cap_eff;
    int   lim_eff;
    logic is_digit;
    logic is_sep;
    logic taking;
    res_t w;
    n  = 0;
    r0 = '0;
    r1 = '0;
    cap_eff  = (cap_reg == 0) ? 1 : ((cap_reg > MaxCapacity) ? MaxCapacity : int'(cap_reg));
    lim_eff  = (lim_reg > MaxValues) ? MaxValues : int'(lim_reg);
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_sep   = (c == ChSpace) || (c == ChComma);
    taking   = int'(taken_count) < lim_eff;

    // no terminator within capacity: string discarded
    if (c != ChNul && char_pos + 1 >= cap_eff) begin
      r0 = mk_word('0, '0, 1'b1, '0, 1'b1, 1'b1);
      n  = 1;
      restart_scan();
      return;
    end

    // a value completes on the first byte after its digits
    if (sc_mode == SCAN_DIGITS && !is_digit) begin
      if (taking) begin
        r0 = mk_word(neg_pending ? (32'd0 - acc_value) : acc_value,
                     taken_count[5:0], 1'b0, '0, 1'b0, 1'b0);
        n  = 1;
        taken_count++;
      end
      sc_mode = is_sep ? SCAN_SEP : SCAN_SKIP_JUNK;
    end

    if (c == ChNul) begin
      w = mk_word('0, '0, 1'b1, taken_count, 1'b0, 1'b1);
      if (n == 0) r0 = w;
      else r1 = w;
      n++;
      restart_scan();
      return;
    end

    char_pos++;
    case (sc_mode)
      SCAN_DIGITS: acc_value = acc_value * 32'd10 + 32'(c - ChZero);
      SCAN_MINUS: begin
        if (is_digit) begin
          acc_value = 32'(c - ChZero);
          sc_mode   = SCAN_DIGITS;
        end else begin
          sc_mode = (c == ChComma) ? SCAN_SEP : SCAN_SKIP_COMMA;
        end
      end
      SCAN_SKIP_COMMA: if (c == ChComma) sc_mode = SCAN_SEP;
      SCAN_SKIP_JUNK:  if (is_sep) sc_mode = SCAN_SEP;
      default: begin
        if (is_sep) begin
          sc_mode = SCAN_SEP;
        end else if (c == ChMinus) begin
          neg_pending = 1'b1;
          sc_mode     = SCAN_MINUS;
        end else if (is_digit) begin
          neg_pending = 1'b0;
          acc_value   = 32'(c - ChZero);
          sc_mode     = SCAN_DIGITS;
        end else begin
          sc_mode = SCAN_SKIP_COMMA;
        end
      end
    endcase
    if (sc_mode == SCAN_SEP) neg_pending = 1'b0;
    if (n == 1) r0.last_of_run = 1'b1;
  endfunction

  function automatic void push_words(input int n, input res_t r0, input res_t r1);
    if (n > 0) expected_words.push_back(r0);
    if (n > 1) expected_words.push_back(r1);
  endfunction

  function automatic void row(input row_kind_e k, input logic [12:0] d, input bit typed = 0,
                              input logic [31:0] val = 0, input int idx = 0,
                              input bit done = 0, input int cnt = 0, input bit ovr = 0);
    row_t r;
    r.kind  = k;
    r.data  = d;
    r.typed = typed;
    r.want  = mk_word(val, 6'(idx), done, 7'(cnt), ovr, 1'b1);
    dir_rows.push_back(r);
  endfunction

  function automatic void row_text(input string s);
    for (int i = 0; i < s.len(); i++) row(ROW_BYTE, 13'(s[i]));
  endfunction

  // any non-NUL byte that is neither a digit nor a separator
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while ((b >= ChZero && b <= ChNine) || b == ChComma || b == ChSpace);
    return b;
  endfunction

  // one string: mostly well-formed lists, some noise and broken tokens
  function automatic void make_string(input bit allow_nul);
    int         ntok;
    int         len;
    logic [7:0] b;
    string      big;
    text_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 24);
      repeat (len) begin
        b = 8'($urandom);
        if (!allow_nul && b == ChNul) b = ChMinus;
        text_buf.push_back(b);
      end
    end else begin
      ntok = $urandom_range(0, 12);
      for (int t = 0; t < ntok; t++) begin
        repeat ($urandom_range(0, 2)) text_buf.push_back($urandom_range(0, 1) ? ChComma : ChSpace);
        if ($urandom_range(0, 3) == 0) text_buf.push_back(ChMinus);
        case ($urandom_range(0, 15))
          0: text_buf.push_back(junk_byte());        // token without digits
          1: begin
            big = wide_numbers[$urandom_range(0, 3)];
            for (int i = 0; i < big.len(); i++) text_buf.push_back(big[i]);
          end
          default: begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            repeat (len) text_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
          end
        endcase
        if ($urandom_range(0, 7) == 0) text_buf.push_back(junk_byte());  // trailing junk
        text_buf.push_back($urandom_range(0, 2) == 0 ? ChSpace : ChComma);
      end
    end
    if (allow_nul && $urandom_range(0, 9) != 0) text_buf.push_back(ChNul);
  endfunction

  // offer one text word and predict once it is taken
  task automatic send_byte(input logic [7:0] b, output int n, output res_t r0, output res_t r1);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    parse_char(b, n, r0, r1);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    int   n;
    res_t r0;
    res_t r1;
    send_byte(b, n, r0, r1);
    push_words(n, r0, r1);
    if (!calm && !tx_quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // sender pauses until every expected word has come
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgCapacity) cap_reg = d;
    else lim_reg = d[LimW-1:0];
  endtask

  task automatic set_limits(input logic [12:0] cap, input logic [6:0] lim);
    settle();
    write_reg(CfgCapacity, cap);
    write_reg(CfgLimit, {6'($urandom_range(0, 63)), lim});
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic run_strings(input int budget, input bit allow_nul);
    int sent;
    sent = 0;
    while (sent < budget) begin
      make_string(allow_nul);
      tx_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < text_buf.size(); i++) feed(text_buf[i]);
      sent += text_buf.size();
    end
    tx_quiet = 1'b0;
  endtask

  // receiver: random stall bursts, plus a long hold when requested
  initial begin
    int n;
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!calm && !rx_quiet && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
        if ($urandom_range(0, 40) == 0) rx_quiet = !rx_quiet;
      end
    end
  end

  // result checker and run timeout
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d words outstanding", cycles,
                 expected_words.size());
        $display("FAILED: results differ");
        $finish;
      end else if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("word with nothing expected, parsed_value", $signed(m_tdata[ValW-1:0]), 0);
        end else begin
          want = expected_words.pop_front();
          if (want.is_done && !want.overrun) done_words++;
          if (want.overrun) overrun_words++;
          if ($signed(m_tdata[ValW-1:0]) !== want.parsed_value)
            flag_mismatch("parsed_value", $signed(m_tdata[ValW-1:0]), want.parsed_value);
          if (m_tdata[IdxLsb +: IdxW] !== want.value_index)
            flag_mismatch("value_index", m_tdata[IdxLsb +: IdxW], want.value_index);
          if (m_tuser[UserDoneBit] !== want.is_done)
            flag_mismatch("is_done", m_tuser[UserDoneBit], want.is_done);
          if (m_tdata[CntLsb +: CntW] !== want.value_count)
            flag_mismatch("value_count", m_tdata[CntLsb +: CntW], want.value_count);
          if (m_tuser[UserOvrBit] !== want.overrun)
            flag_mismatch("overrun", m_tuser[UserOvrBit], want.overrun);
          if (m_tlast !== want.last_of_run)
            flag_mismatch("last_of_run", m_tlast, want.last_of_run);
        end
        words_checked++;
      end
    end
  end

  // stimulus
  initial begin
    int   n;
    res_t r0;
    res_t r1;
    cap_reg = CapReset;
    lim_reg = LimReset;
    restart_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, registers at their reset values until capacity is set to one
    row(ROW_BYTE, ChNul, 1, 0, 0, 1, 0, 0);               // empty string after reset
    row(ROW_BYTE, ChMinus);
    row_text("2147483648");
    row(ROW_BYTE, ChComma, 1, 32'h8000_0000, 0);          // most negative value
    row_text("9");
    row(ROW_BYTE, 8'hFF, 1, 9, 1);                        // junk ends a value
    row_text(" -b,5");                                    // minus with no digits
    row(ROW_BYTE, ChNul);                                 // value then done
    row(ROW_SET_CAP, 13'd1);
    row(ROW_BYTE, "A", 1, 0, 0, 1, 0, 1);                 // overrun on first byte
    row(ROW_BYTE, ChNul, 1, 0, 0, 1, 0, 0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SET_CAP) begin
        settle();
        write_reg(CfgCapacity, dir_rows[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send_byte(dir_rows[i].data[7:0], n, r0, r1);
        if (dir_rows[i].typed) expected_words.push_back(dir_rows[i].want);
        else push_words(n, r0, r1);
      end
    end

    // register extremes, including out-of-range settings
    set_limits(13'd0, 7'd8);
    run_strings(30, 1'b1);
    set_limits(13'd2, 7'd1);
    run_strings(30, 1'b1);
    set_limits(13'd64, 7'd0);
    run_strings(40, 1'b1);
    set_limits(13'd4096, 7'd64);
    run_strings(60, 1'b1);

    // long receiver hold while the sender keeps going past the value limit
    set_limits(13'd4096, 7'd64);
    text_buf.delete();
    repeat (75) begin
      text_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
      text_buf.push_back(ChComma);
    end
    text_buf.push_back(ChNul);
    tx_quiet = 1'b1;
    rx_hold = 120;
    for (int i = 0; i < text_buf.size(); i++) feed(text_buf[i]);
    tx_quiet = 1'b0;

    // register values above range clamp to the largest capacity and limit
    set_limits(13'h1FFF, 7'h7F);
    run_strings(40, 1'b1);

    repeat (3) begin
      set_limits(13'($urandom_range(3, 300)), 7'($urandom_range(1, 70)));
      run_strings(40, 1'b1);
    end

    // last part without idling
    set_limits(13'd200, 7'd8);
    calm = 1'b1;
    run_strings(60, 1'b1);
    make_string(1'b0);
    text_buf.push_back(ChNul);
    for (int i = 0; i < text_buf.size(); i++) feed(text_buf[i]);

    settle();
    $display("sent %0d text bytes under %0d register settings, checked %0d result words",
             bytes_sent, settings_run + 1, words_checked);
    $display("%0d strings closed by terminator, %0d by overrun", done_words, overrun_words);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
